### design/rgbf_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and per-channel filter functions for the RGB 3x3 image filter.
// Depends on nothing; every other design file but rgbf_ram imports it.
package rgbf_pkg;

    localparam int MaxWidth   = 2048;
    localparam int AddrW      = $clog2(MaxWidth);
    localparam int PixW       = 24;
    localparam int ColW       = AddrW;
    localparam int RowW       = 12;
    localparam int DimW       = 12;
    localparam int CountW     = 24;
    localparam int QueueDepth = 4;
    localparam int QPtrW      = $clog2(QueueDepth);

    localparam logic [1:0] ModeLaplace = 2'd0;
    localparam logic [1:0] ModeGauss   = 2'd1;
    localparam logic [1:0] ModeMedian  = 2'd2;
    localparam logic [1:0] ModeSobel   = 2'd3;

    localparam logic [1:0] RegMode   = 2'd0;
    localparam logic [1:0] RegWidth  = 2'd1;
    localparam logic [1:0] RegHeight = 2'd2;

    localparam logic [DimW-1:0]   ResetWidth  = 12'd1280;
    localparam logic [DimW-1:0]   ResetHeight = 12'd960;
    localparam logic [DimW-1:0]   MinDim      = 12'd3;
    localparam logic [DimW-1:0]   MaxWidthDim = 12'd2048;
    localparam logic [CountW-1:0] ResetTotal  = 24'd1228800;

    typedef struct packed {
        logic       action;
        logic [7:0] in_blue;
        logic [7:0] in_green;
        logic [7:0] in_red;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_blue;
        logic [7:0] out_green;
        logic [7:0] out_red;
        logic       last_of_frame;
    } out_item_t;

    // One classified request handed from the front to the back.
    typedef struct packed {
        logic             is_drain;
        logic             emit;
        logic             border;
        logic             last;
        logic [AddrW-1:0] addr;
        logic [PixW-1:0]  pix;
    } cmd_t;

    typedef logic [8:0][7:0] taps_t;

    function automatic logic [7:0] min2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [7:0] max2(input logic [7:0] a, input logic [7:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [7:0] med3(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    // Median of nine: sort rows, then max of mins, median of mids, min of maxes.
    function automatic logic [7:0] median9(input taps_t t);
        logic [7:0] lo0, lo1, lo2, md0, md1, md2, hi0, hi1, hi2;
        lo0 = min2(min2(t[0], t[1]), t[2]);
        lo1 = min2(min2(t[3], t[4]), t[5]);
        lo2 = min2(min2(t[6], t[7]), t[8]);
        hi0 = max2(max2(t[0], t[1]), t[2]);
        hi1 = max2(max2(t[3], t[4]), t[5]);
        hi2 = max2(max2(t[6], t[7]), t[8]);
        md0 = med3(t[0], t[1], t[2]);
        md1 = med3(t[3], t[4], t[5]);
        md2 = med3(t[6], t[7], t[8]);
        return med3(max2(max2(lo0, lo1), lo2), med3(md0, md1, md2),
                    min2(min2(hi0, hi1), hi2));
    endfunction

    function automatic logic [7:0] filt_channel(input logic [1:0] mode, input taps_t t);
        logic signed [11:0] lap;
        logic [8:0]         gss;
        logic [9:0]         px, nx, py, ny, ax, ay;
        logic [10:0]        sob;
        logic [7:0]         res;
        lap = $signed({2'b00, t[4], 2'b00}) - $signed({4'b0000, t[1]})
            - $signed({4'b0000, t[3]}) - $signed({4'b0000, t[5]})
            - $signed({4'b0000, t[7]});
        gss = {5'd0, t[0][7:4]} + {5'd0, t[2][7:4]} + {5'd0, t[6][7:4]}
            + {5'd0, t[8][7:4]} + {4'd0, t[1][7:3]} + {4'd0, t[3][7:3]}
            + {4'd0, t[5][7:3]} + {4'd0, t[7][7:3]} + {3'd0, t[4][7:2]};
        px = {2'b00, t[2]} + {1'b0, t[5], 1'b0} + {2'b00, t[8]};
        nx = {2'b00, t[0]} + {1'b0, t[3], 1'b0} + {2'b00, t[6]};
        py = {2'b00, t[6]} + {1'b0, t[7], 1'b0} + {2'b00, t[8]};
        ny = {2'b00, t[0]} + {1'b0, t[1], 1'b0} + {2'b00, t[2]};
        ax = (px >= nx) ? px - nx : nx - px;
        ay = (py >= ny) ? py - ny : ny - py;
        sob = {1'b0, ax} + {1'b0, ay};
        case (mode)
            ModeLaplace: begin
                if (lap < 0)
                    res = 8'd0;
                else if (lap > 12'sd255)
                    res = 8'd255;
                else
                    res = lap[7:0];
            end
            ModeGauss:  res = gss[7:0];
            ModeMedian: res = median9(t);
            ModeSobel:  res = (sob > 11'd255) ? 8'd255 : sob[7:0];
            default:    res = 8'd0;
        endcase
        return res;
    endfunction

endpackage

### design/rgbf_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module rgbf_ram #(
    parameter int Width = 24,
    parameter int Depth = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/rgbf_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, raster position counters, pending count,
// classification of input items into line-store requests. Depends on rgbf_pkg.
module rgbf_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rgbf_pkg::in_item_t  in_item,
    input  logic                wr_en,
    input  logic [1:0]          wr_index,
    input  logic [11:0]         wr_data,
    input  logic                q_full,
    output logic                push,
    output rgbf_pkg::cmd_t      push_cmd,
    output logic [1:0]          mode
);
    import rgbf_pkg::*;

    logic [1:0]        mode_reg;
    logic [DimW-1:0]   wid_reg, hgt_reg;
    logic [RowW-1:0]   in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [ColW-1:0]   in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [CountW-1:0] pend_reg, pend_next, tot_reg;
    logic [CountW-1:0] prod_a_reg, prod_b_reg;
    logic [1:0]        recalc_reg;
    logic              mod_busy_reg;
    logic [4:0]        mod_cnt_reg;
    logic [CountW-1:0] rem_reg, rem_next, dvd_reg;

    logic [DimW-1:0]   ew, eh;
    logic              accept, emit, drain_ok, out_step, off_frame, mod_start;
    logic [DimW-1:0]   ic1, oc1;
    logic [RowW-1:0]   ir1, or1;
    logic [CountW-1:0] p1, sum_a, sum_b, diff_ba, rem_shift;

    assign ew = (wid_reg < MinDim) ? MinDim : ((wid_reg > MaxWidthDim) ? MaxWidthDim : wid_reg);
    assign eh = (hgt_reg < MinDim) ? MinDim : hgt_reg;

    assign mode     = mode_reg;
    assign in_ready = !q_full && (recalc_reg == 2'd0) && !mod_busy_reg;
    assign accept   = in_valid && in_ready;

    assign ic1 = {1'b0, in_col_reg} + 12'd1;
    assign oc1 = {1'b0, out_col_reg} + 12'd1;
    assign ir1 = in_row_reg + 12'd1;
    assign or1 = out_row_reg + 12'd1;

    assign emit     = pend_reg > {12'd0, ew};
    assign drain_ok = (in_row_reg == '0) && (in_col_reg == '0) && (pend_reg != '0);
    assign push     = accept && (!in_item.action || drain_ok);
    assign out_step = push && (in_item.action || emit);

    // A position past the current frame edge breaks the running count.
    assign off_frame = (in_row_reg >= eh) || ({1'b0, in_col_reg} >= ew)
                    || (out_row_reg >= eh) || ({1'b0, out_col_reg} >= ew);

    assign sum_a   = prod_a_reg + {13'd0, in_col_reg};
    assign sum_b   = prod_b_reg + {13'd0, out_col_reg};
    assign diff_ba = sum_b - sum_a;

    // Output position a frame or more ahead: reduce the gap modulo the frame size.
    assign mod_start = (recalc_reg == 2'd1) && (sum_a < sum_b) && (diff_ba >= tot_reg);
    assign rem_shift = {rem_reg[CountW-2:0], dvd_reg[CountW-1]};
    assign rem_next  = (rem_shift >= tot_reg) ? rem_shift - tot_reg : rem_shift;

    always_comb
    begin
        push_cmd.is_drain = in_item.action;
        push_cmd.emit     = in_item.action || emit;
        push_cmd.border   = (out_row_reg == '0) || (out_row_reg >= eh - 12'd1)
                          || (out_col_reg == '0) || ({1'b0, out_col_reg} >= ew - 12'd1);
        push_cmd.last     = (out_row_reg == eh - 12'd1) && ({1'b0, out_col_reg} == ew - 12'd1);
        push_cmd.pix      = {in_item.in_red, in_item.in_green, in_item.in_blue};
        if (in_item.action)
            push_cmd.addr = (oc1 >= ew) ? '0 : oc1[AddrW-1:0];
        else
            push_cmd.addr = in_col_reg;
    end

    always_comb
    begin
        in_row_next  = in_row_reg;
        in_col_next  = in_col_reg;
        out_row_next = out_row_reg;
        out_col_next = out_col_reg;
        pend_next    = pend_reg;
        p1           = (pend_reg + 24'd1 == tot_reg) ? '0 : pend_reg + 24'd1;
        if (accept && !in_item.action)
        begin
            if (ic1 >= ew)
            begin
                in_col_next = '0;
                in_row_next = (ir1 >= eh) ? '0 : ir1;
            end
            else
            begin
                in_col_next = ic1[ColW-1:0];
            end
            if (emit)
                pend_next = (p1 == '0) ? tot_reg - 24'd1 : p1 - 24'd1;
            else
                pend_next = p1;
        end
        else if (push)
        begin
            pend_next = pend_reg - 24'd1;
        end
        if (out_step)
        begin
            if (oc1 >= ew)
            begin
                out_col_next = '0;
                out_row_next = (or1 >= eh) ? '0 : or1;
            end
            else
            begin
                out_col_next = oc1[ColW-1:0];
            end
        end
        // Rebuild the pending count from positions once a new frame size settles.
        if (recalc_reg == 2'd1)
        begin
            if (sum_a >= sum_b)
                pend_next = sum_a - sum_b;
            else if (diff_ba < tot_reg)
                pend_next = tot_reg - diff_ba;
        end
        if (mod_busy_reg && (mod_cnt_reg == 5'd0))
            pend_next = (rem_next == '0) ? '0 : tot_reg - rem_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= ModeLaplace;
            wid_reg      <= ResetWidth;
            hgt_reg      <= ResetHeight;
            in_row_reg   <= '0;
            in_col_reg   <= '0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            pend_reg     <= '0;
            tot_reg      <= ResetTotal;
            recalc_reg   <= 2'd0;
            mod_busy_reg <= 1'b0;
            mod_cnt_reg  <= 5'd0;
            rem_reg      <= '0;
            dvd_reg      <= '0;
        end
        else
        begin
            in_row_reg  <= in_row_next;
            in_col_reg  <= in_col_next;
            out_row_reg <= out_row_next;
            out_col_reg <= out_col_next;
            pend_reg    <= pend_next;
            if (wr_en)
            begin
                recalc_reg <= 2'd2;
                case (wr_index)
                    RegMode:   mode_reg <= wr_data[1:0];
                    RegWidth:  wid_reg  <= wr_data;
                    RegHeight: hgt_reg  <= wr_data;
                    default:   ;
                endcase
            end
            else if (push && off_frame)
            begin
                recalc_reg <= 2'd2;
            end
            else if (recalc_reg != 2'd0)
            begin
                recalc_reg <= recalc_reg - 2'd1;
            end
            if (recalc_reg == 2'd2)
                tot_reg <= {12'd0, ew} * {12'd0, eh};
            // One remainder bit per cycle, most significant first.
            if (wr_en)
            begin
                mod_busy_reg <= 1'b0;
            end
            else if (mod_start)
            begin
                mod_busy_reg <= 1'b1;
                mod_cnt_reg  <= 5'd23;
                rem_reg      <= '0;
                dvd_reg      <= diff_ba;
            end
            else if (mod_busy_reg)
            begin
                rem_reg     <= rem_next;
                dvd_reg     <= {dvd_reg[CountW-2:0], 1'b0};
                mod_cnt_reg <= mod_cnt_reg - 5'd1;
                if (mod_cnt_reg == 5'd0)
                    mod_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_a_reg <= {12'd0, in_row_reg} * {12'd0, ew};
        prod_b_reg <= {12'd0, out_row_reg} * {12'd0, ew};
    end

endmodule

### design/rgbf_queue.sv
`timescale 1ns / 1ps
// Short request queue between the front and back ends.
// Depends on rgbf_pkg.
module rgbf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rgbf_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output rgbf_pkg::cmd_t  pop_cmd
);
    import rgbf_pkg::*;

    cmd_t             slot_reg [QueueDepth];
    logic [QPtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPtrW:0]   cnt_reg;

    assign full      = cnt_reg == QueueDepth[QPtrW:0];
    assign pop_valid = cnt_reg != '0;
    assign pop_cmd   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPtrW'(1);
            if (pop && pop_valid)
                rd_ptr_reg <= rd_ptr_reg + QPtrW'(1);
            if (push && !(pop && pop_valid))
                cnt_reg <= cnt_reg + (QPtrW+1)'(1);
            else if (!push && pop && pop_valid)
                cnt_reg <= cnt_reg - (QPtrW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

### design/rgbf_back.sv
`timescale 1ns / 1ps
// Back end: line stores, 3x3 window, filter and output register.
// Depends on rgbf_pkg and rgbf_ram.
module rgbf_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [1:0]           mode,
    input  logic                 q_valid,
    input  rgbf_pkg::cmd_t       q_cmd,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rgbf_pkg::out_item_t  out_item
);
    import rgbf_pkg::*;

    logic                  adv, st_wr;
    logic                  s1_valid_reg, fwd_hit_reg;
    cmd_t                  s1_cmd_reg;
    logic [PixW-1:0]       fwd_top_reg, fwd_mid_reg;
    logic [PixW-1:0]       up_rd, mid_rd, s1_top, s1_mid, s1_bot;
    logic [8:0][PixW-1:0]  win_reg;
    logic                  s2_valid_reg, s2_border_reg, s2_last_reg;
    logic                  out_valid_reg;
    out_item_t             out_item_reg, out_item_next;
    taps_t                 tb, tg, tr;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && q_valid;
    assign st_wr = adv && s1_valid_reg && !s1_cmd_reg.is_drain;

    assign s1_top = fwd_hit_reg ? fwd_top_reg : up_rd;
    assign s1_mid = fwd_hit_reg ? fwd_mid_reg : mid_rd;
    assign s1_bot = s1_cmd_reg.is_drain ? '0 : s1_cmd_reg.pix;

    rgbf_ram #(.Width(PixW), .Depth(MaxWidth)) u_upper (
        .clk     (clk),
        .wr_en   (st_wr),
        .wr_addr (s1_cmd_reg.addr),
        .wr_data (s1_mid),
        .rd_en   (q_pop),
        .rd_addr (q_cmd.addr),
        .rd_data (up_rd)
    );

    rgbf_ram #(.Width(PixW), .Depth(MaxWidth)) u_middle (
        .clk     (clk),
        .wr_en   (st_wr),
        .wr_addr (s1_cmd_reg.addr),
        .wr_data (s1_cmd_reg.pix),
        .rd_en   (q_pop),
        .rd_addr (q_cmd.addr),
        .rd_data (mid_rd)
    );

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            tb[i] = win_reg[i][7:0];
            tg[i] = win_reg[i][15:8];
            tr[i] = win_reg[i][23:16];
        end
        out_item_next.last_of_frame = s2_last_reg;
        if (s2_border_reg)
        begin
            out_item_next.out_blue  = tb[4];
            out_item_next.out_green = tg[4];
            out_item_next.out_red   = tr[4];
        end
        else
        begin
            out_item_next.out_blue  = filt_channel(mode, tb);
            out_item_next.out_green = filt_channel(mode, tg);
            out_item_next.out_red   = filt_channel(mode, tr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            win_reg       <= '0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= q_valid;
            // Bypass a store write that lands on the address read in the same cycle.
            fwd_hit_reg   <= st_wr && (q_cmd.addr == s1_cmd_reg.addr);
            s2_valid_reg  <= s1_valid_reg && s1_cmd_reg.emit;
            out_valid_reg <= s2_valid_reg;
            if (s1_valid_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3]     <= win_reg[r*3+1];
                    win_reg[r*3+1]   <= win_reg[r*3+2];
                end
                win_reg[2] <= s1_top;
                win_reg[5] <= s1_mid;
                win_reg[8] <= s1_bot;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cmd_reg    <= q_cmd;
            fwd_top_reg   <= s1_mid;
            fwd_mid_reg   <= s1_cmd_reg.pix;
            s2_border_reg <= s1_cmd_reg.border;
            s2_last_reg   <= s1_cmd_reg.last;
            out_item_reg  <= out_item_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

### design/rgb_3x3_image_filter_unit.sv
`timescale 1ns / 1ps
// RGB 3x3 image filter. Throughput: one item per clock while out_ready holds high and
// no rebuild holds in_ready low. A request leaving the 4-entry queue passes the
// line-store read, window shift and filter into the output register; a frame's
// output trails its input by one row plus one pixel. Input stalls after a register
// write or a request taken past a shrunken frame, longer if output is a frame ahead.
// Reset clears counters, window and queue; line stores stay undefined until written.
module rgb_3x3_image_filter_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rgbf_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rgbf_pkg::out_item_t  out_item,
    input  logic                 wr_en,
    input  logic [1:0]           wr_index,
    input  logic [11:0]          wr_data
);
    import rgbf_pkg::*;

    logic       push, q_full, q_pop, q_valid;
    cmd_t       push_cmd, q_cmd;
    logic [1:0] mode;

    // Classify items, track raster positions, hold the configuration.
    rgbf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd),
        .mode     (mode)
    );

    // Decouple the two ends so each can stall on its own.
    rgbf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    // Read and update line stores, advance the window, filter, drive results.
    rgbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mode      (mode),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

`ifndef ASSERT_OFF
    a_cfg_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> !in_ready)
        else $error("input taken during pending-count rebuild");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("request pushed into full queue");

    a_pop_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !q_pop)
        else $error("queue popped while output stalled");
`endif

endmodule

### bench/rgb_3x3_image_filter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for rgb_3x3_image_filter_unit: streams frames of RGB pixels
// and drain ticks, predicts every filtered pixel and checks each one on arrival.
// Depends on rgbf_pkg and the rgb_3x3_image_filter_unit RTL.
module rgb_3x3_image_filter_unit_test;
    import rgbf_pkg::*;

    localparam int LineDepth    = 2048;
    localparam int HeightCap    = 4096;
    localparam int SettleCycles = 20;     // queue plus three pipeline stages, with margin
    localparam int StallLimit   = 5000;   // cycles without any handshake

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    logic        wr_en;
    logic [1:0]  wr_index;
    logic [11:0] wr_data;

    rgb_3x3_image_filter_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Pixel predictor: own copy of registers, line stores, window, counters
    // ------------------------------------------------------------------
    int unsigned   pred_mode;
    int unsigned   pred_width;
    int unsigned   pred_height;
    logic [23:0]   upper_line  [LineDepth];
    logic [23:0]   middle_line [LineDepth];
    logic [23:0]   win [9];
    int unsigned   in_row, in_col, out_row, out_col;
    out_item_t     expected_pixels [$];

    int errors;
    int requests_sent;
    int pixels_checked;
    int frames_sent;
    int drains_sent;
    int idle_cycles;

    function automatic int unsigned active_width();
        if (pred_width < 3) return 3;
        if (pred_width > LineDepth) return LineDepth;
        return pred_width;
    endfunction

    function automatic int unsigned active_height();
        if (pred_height < 3) return 3;
        if (pred_height > HeightCap) return HeightCap;
        return pred_height;
    endfunction

    // Pixels accepted but not yet produced, within the frame.
    function automatic longint pixels_pending();
        longint w, total, a, b, d;
        w = longint'(active_width());
        total = w * longint'(active_height());
        a = longint'(in_row) * w + longint'(in_col);
        b = longint'(out_row) * w + longint'(out_col);
        if (a >= b) return a - b;
        d = (b - a) % total;
        return (d != 0) ? total - d : 0;
    endfunction

    function automatic void shift_window(logic [23:0] top, logic [23:0] mid,
                                         logic [23:0] bot);
        for (int r = 0; r < 3; r++)
        begin
            win[r*3]     = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = bot;
    endfunction

    function automatic logic [7:0] filter_one_channel(int sh);
        int t[9];
        int v, gx, gy, k, j;
        for (int i = 0; i < 9; i++)
            t[i] = int'(win[i][sh +: 8]);
        case (pred_mode)
            ModeLaplace: v = 4 * t[4] - t[1] - t[3] - t[5] - t[7];
            ModeGauss:   v = (t[0] >> 4) + (t[2] >> 4) + (t[6] >> 4) + (t[8] >> 4)
                           + (t[1] >> 3) + (t[3] >> 3) + (t[5] >> 3) + (t[7] >> 3)
                           + (t[4] >> 2);
            ModeMedian:
            begin
                for (int i = 1; i < 9; i++)
                begin
                    k = t[i];
                    j = i - 1;
                    while (j >= 0 && t[j] > k)
                    begin
                        t[j + 1] = t[j];
                        j--;
                    end
                    t[j + 1] = k;
                end
                v = t[4];
            end
            default:
            begin
                gx = -t[0] + t[2] - 2 * t[3] + 2 * t[5] - t[6] + t[8];
                gy = -t[0] - 2 * t[1] - t[2] + t[6] + 2 * t[7] + t[8];
                v = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
            end
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // Produce the pixel at the output position and advance it.
    function automatic void produce_pixel(int unsigned w, int unsigned h);
        out_item_t px;
        logic      on_border;
        on_border = (out_row == 0) || (out_row >= h - 1) || (out_col == 0)
                 || (out_col >= w - 1);
        px.out_blue      = on_border ? win[4][7:0]   : filter_one_channel(0);
        px.out_green     = on_border ? win[4][15:8]  : filter_one_channel(8);
        px.out_red       = on_border ? win[4][23:16] : filter_one_channel(16);
        px.last_of_frame = (out_row == h - 1) && (out_col == w - 1);
        expected_pixels.push_back(px);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
            if (out_row >= h) out_row = 0;
        end
    endfunction

    function automatic void predict_request(in_item_t it);
        int unsigned w, h, c;
        longint      pend;
        logic [23:0] pix, top, mid;
        w = active_width();
        h = active_height();
        pend = pixels_pending();
        if (it.action == 1'b0)
        begin
            pix = {it.in_red, it.in_green, it.in_blue};
            c = in_col % LineDepth;
            top = upper_line[c];
            mid = middle_line[c];
            upper_line[c] = mid;
            middle_line[c] = pix;
            shift_window(top, mid, pix);
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
                if (in_row >= h) in_row = 0;
            end
            if (pend >= longint'(w) + 1) produce_pixel(w, h);
        end
        else if (in_row == 0 && in_col == 0 && pend != 0)
        begin
            // drain: feed the stored column with an empty bottom row
            c = out_col + 1;
            if (c >= w) c = 0;
            c = c % LineDepth;
            shift_window(upper_line[c], middle_line[c], 24'd0);
            produce_pixel(w, h);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: predict on input handshakes, check on output handshakes
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_request(in_item);
                requests_sent++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $display("%0t: unexpected pixel %h", $time, out_item);
                    errors++;
                end
                else
                begin
                    if (out_item.out_blue !== expected_pixels[0].out_blue)
                    begin
                        $display("%0t: out_blue expected %h actual %h", $time,
                                 expected_pixels[0].out_blue, out_item.out_blue);
                        errors++;
                    end
                    if (out_item.out_green !== expected_pixels[0].out_green)
                    begin
                        $display("%0t: out_green expected %h actual %h", $time,
                                 expected_pixels[0].out_green, out_item.out_green);
                        errors++;
                    end
                    if (out_item.out_red !== expected_pixels[0].out_red)
                    begin
                        $display("%0t: out_red expected %h actual %h", $time,
                                 expected_pixels[0].out_red, out_item.out_red);
                        errors++;
                    end
                    if (out_item.last_of_frame !== expected_pixels[0].last_of_frame)
                    begin
                        $display("%0t: last_of_frame expected %b actual %b", $time,
                                 expected_pixels[0].last_of_frame, out_item.last_of_frame);
                        errors++;
                    end
                    void'(expected_pixels.pop_front());
                    pixels_checked++;
                end
            end
            // watchdog: any handshake restarts the count
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= StallLimit)
            begin
                $display("%0t: no progress for %0d cycles", $time, StallLimit);
                $display("rgb_3x3_image_filter_unit_test: errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, a long hold on request, none when quiet
    // ------------------------------------------------------------------
    bit quiet;
    int hold_left;
    int stall_left;

    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (quiet)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            stall_left = $urandom_range(1, 14) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Sender side; every task starts and ends at a falling edge
    // ------------------------------------------------------------------
    task automatic send_request(input in_item_t it);
        int target;
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        target = requests_sent + 1;
        in_item  <= it;
        in_valid <= 1'b1;
        do @(negedge clk); while (requests_sent < target);
    endtask

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        in_item_t it;
        it.action   = 1'b0;
        it.in_red   = r;
        it.in_green = g;
        it.in_blue  = b;
        send_request(it);
    endtask

    task automatic send_drain();
        in_item_t it;
        it.action   = 1'b1;
        it.in_red   = 8'($urandom_range(0, 255));
        it.in_green = 8'($urandom_range(0, 255));
        it.in_blue  = 8'($urandom_range(0, 255));
        send_request(it);
        drains_sent++;
    endtask

    // Drop valid and hold until every expected pixel has come out.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0) @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // Drive one write for a cycle; the caller drops the enable after the last one.
    task automatic write_register(input logic [1:0] idx, input logic [11:0] value);
        in_valid <= 1'b0;
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= value;
        @(negedge clk);
        case (idx)
            RegMode:   pred_mode   = 32'(value[1:0]);
            RegWidth:  pred_width  = 32'(value);
            RegHeight: pred_height = 32'(value);
            default: ;
        endcase
    endtask

    task automatic configure(input logic [1:0] mode, input logic [11:0] w,
                             input logic [11:0] h);
        write_register(RegMode, {10'd0, mode});
        write_register(RegWidth, w);
        write_register(RegHeight, h);
        wr_en <= 1'b0;
    endtask

    // One full frame of random pixels, with optional stray drains.
    task automatic send_frame(input int noise_pct);
        int n;
        n = active_width() * active_height();
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < noise_pct) send_drain();
            send_pixel(random_level(), random_level(), random_level());
        end
        frames_sent++;
    endtask

    task automatic flush_tail();
        while (pixels_pending() != 0) send_drain();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Smallest frame, sizes clamped up from below, extreme pixels, ignored drains.
    task automatic test_smallest_frame();
        configure(ModeLaplace, 12'd1, 12'd0);
        send_drain();                           // nothing pending: ignored
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_drain();                           // mid-frame: ignored
        send_pixel(8'hFF, 8'h00, 8'h01);        // center: blue saturates low, red and green cancel to zero
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        send_pixel(8'hFF, 8'h00, 8'hFF);
        send_pixel(8'h00, 8'hFF, 8'h00);
        flush_tail();
        send_drain();                           // tail flushed: ignored
        frames_sent++;
        wait_until_drained();
    endtask

    // Each filter on a small frame.
    task automatic test_each_filter();
        for (int m = 0; m < 4; m++)
        begin
            configure(m[1:0], 12'd5, 12'd4);
            send_frame(0);
            flush_tail();
            wait_until_drained();
        end
    endtask

    // Hold the receiver off long enough that the block fills and stalls its input.
    task automatic test_output_hold();
        configure(ModeLaplace, 12'd8, 12'd6);
        hold_left = 400;
        send_frame(0);
        flush_tail();
        wait_until_drained();
    endtask

    // Random sizes and filters; back-to-back frames that cut into the tail.
    task automatic test_random_frames(input int budget);
        int start;
        int cut;
        start = requests_sent;
        while (requests_sent - start < budget)
        begin
            if (requests_sent - start > budget * 4 / 5) quiet = 1'b1;
            configure(2'($urandom_range(0, 3)), 12'($urandom_range(3, 9)),
                      12'($urandom_range(3, 6)));
            repeat ($urandom_range(1, 3))
            begin
                send_frame(5);
                // cut the tail short and start the next frame on top of it
                cut = $urandom_range(0, active_width());
                for (int i = 0; i < cut; i++) send_drain();
            end
            send_frame(5);
            flush_tail();
            wait_until_drained();
        end
        // close with one frame free of any idling
        quiet = 1'b1;
        configure(ModeMedian, 12'd7, 12'd5);
        send_frame(0);
        flush_tail();
        wait_until_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_item   = '0;
        out_ready = 1'b0;
        wr_en     = 1'b0;
        wr_index  = '0;
        wr_data   = '0;
        quiet       = 1'b0;
        hold_left   = 0;
        stall_left  = 0;
        errors      = 0;
        idle_cycles = 0;
        pred_mode   = 0;
        pred_width  = 1280;
        pred_height = 960;
        for (int i = 0; i < LineDepth; i++)
        begin
            upper_line[i]  = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_smallest_frame();
        test_each_filter();
        test_output_hold();
        test_random_frames(300);

        wait_until_drained();
        $display("Covered %0d frames, %0d drain ticks, %0d pixels checked;",
                 frames_sent, drains_sent, pixels_checked);
        $display("all four filters, clamped sizes, tail cut-ins and a long output hold.");
        if (errors == 0)
            $display("rgb_3x3_image_filter_unit_test: clean");
        else
            $display("rgb_3x3_image_filter_unit_test: errors");
        $finish;
    end

endmodule
